/* rtl/core/trar_pkg.sv */
`timescale 1ns / 1ps

package trar_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // corner differences and their products
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int LEN_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
    localparam int MAG_BITS   = 2 * DIFF_BITS;
    localparam int C_BITS     = 2 * MAG_BITS;
    localparam int L2SQ_BITS  = 2 * LEN_BITS;
    localparam int R_BITS     = L2SQ_BITS + 2 * FRAC_BITS;

    // ratio = isqrt(floor(L2^2 * 2^(2F) / C))
    localparam int OUT_BITS   = 32;
    localparam int ROOT_BITS  = OUT_BITS;
    localparam int QUO_BITS   = 2 * OUT_BITS;
    localparam int CMP_BITS   = R_BITS + C_BITS;

    localparam int FRONT_STAGES = 7;
    localparam int LATENCY      = FRONT_STAGES + QUO_BITS + ROOT_BITS + 1;

    typedef struct packed {
        logic valid;
        logic degen;
        logic sat;
    } trar_ctl_t;

endpackage

/* rtl/core/trar_front.sv */
`timescale 1ns / 1ps

module trar_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [trar_pkg::COORD_BITS-1:0]      c0_x,
    input  logic [trar_pkg::COORD_BITS-1:0]      c0_y,
    input  logic [trar_pkg::COORD_BITS-1:0]      c0_z,
    input  logic [trar_pkg::COORD_BITS-1:0]      c1_x,
    input  logic [trar_pkg::COORD_BITS-1:0]      c1_y,
    input  logic [trar_pkg::COORD_BITS-1:0]      c1_z,
    input  logic [trar_pkg::COORD_BITS-1:0]      c2_x,
    input  logic [trar_pkg::COORD_BITS-1:0]      c2_y,
    input  logic [trar_pkg::COORD_BITS-1:0]      c2_z,
    output trar_pkg::trar_ctl_t                  ctl,
    output logic [trar_pkg::C_BITS-1:0]          divisor,
    output logic [trar_pkg::C_BITS-1:0]          rem,
    output logic [trar_pkg::QUO_BITS-1:0]        low
);
    import trar_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    // stage 1: edge vectors u = p1-p0, w = p2-p0, v = p2-p1
    logic signed [DIFF_BITS-1:0] d_next [9];
    logic signed [DIFF_BITS-1:0] d_reg  [9];

    function automatic logic signed [DIFF_BITS-1:0] sub(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic signed [DIFF_BITS-1:0] ea;
        logic signed [DIFF_BITS-1:0] eb;
        ea = $signed({a[COORD_BITS-1], a});
        eb = $signed({b[COORD_BITS-1], b});
        return ea - eb;
    endfunction

    always_comb
    begin
        d_next[0] = sub(c1_x, c0_x);
        d_next[1] = sub(c1_y, c0_y);
        d_next[2] = sub(c1_z, c0_z);
        d_next[3] = sub(c2_x, c0_x);
        d_next[4] = sub(c2_y, c0_y);
        d_next[5] = sub(c2_z, c0_z);
        d_next[6] = sub(c2_x, c1_x);
        d_next[7] = sub(c2_y, c1_y);
        d_next[8] = sub(c2_z, c1_z);
    end

    // stage 2: cross terms and squared components
    logic signed [PROD_BITS-1:0] xp_reg [6];
    logic signed [PROD_BITS-1:0] sq_reg [9];

    // stage 3: cross product and squared edge lengths
    logic signed [CROSS_BITS-1:0] n_reg [3];
    logic [LEN_BITS-1:0]          len_reg [3];

    // stage 4: magnitudes, longest edge, zero check
    logic [MAG_BITS-1:0] mag_reg [3];
    logic [LEN_BITS-1:0] l2_reg;
    logic                zero_reg;
    logic [LEN_BITS-1:0] l2_next;

    always_comb
    begin
        l2_next = len_reg[0];
        if (len_reg[1] > l2_next)
        begin
            l2_next = len_reg[1];
        end
        if (len_reg[2] > l2_next)
        begin
            l2_next = len_reg[2];
        end
    end

    // stage 5: squares
    logic [C_BITS-1:0]    msq_reg [3];
    logic [L2SQ_BITS-1:0] l2sq_reg;
    logic                 zero5_reg;

    // stage 6: sum of squares
    logic [C_BITS-1:0]    c_reg;
    logic [L2SQ_BITS-1:0] l2sq6_reg;
    logic                 zero6_reg;

    // stage 7: split dividend, range check
    logic [R_BITS+QUO_BITS-1:0] r_ext;
    logic [R_BITS-1:0]          r_hi;
    logic [C_BITS-1:0]          div_reg;
    logic [C_BITS-1:0]          rem_reg;
    logic [QUO_BITS-1:0]        low_reg;
    logic                       sat_reg;
    logic                       degen_reg;

    assign r_ext = (R_BITS + QUO_BITS)'({l2sq6_reg, {(2 * FRAC_BITS){1'b0}}});
    assign r_hi  = r_ext[R_BITS+QUO_BITS-1:QUO_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;

        xp_reg[0] <= d_reg[1] * d_reg[5];
        xp_reg[1] <= d_reg[2] * d_reg[4];
        xp_reg[2] <= d_reg[2] * d_reg[3];
        xp_reg[3] <= d_reg[0] * d_reg[5];
        xp_reg[4] <= d_reg[0] * d_reg[4];
        xp_reg[5] <= d_reg[1] * d_reg[3];
        for (int i = 0; i < 9; i++)
        begin
            sq_reg[i] <= d_reg[i] * d_reg[i];
        end

        for (int i = 0; i < 3; i++)
        begin
            n_reg[i]   <= CROSS_BITS'(xp_reg[2*i]) - CROSS_BITS'(xp_reg[2*i+1]);
            len_reg[i] <= LEN_BITS'($unsigned(sq_reg[3*i]))
                        + LEN_BITS'($unsigned(sq_reg[3*i+1]))
                        + LEN_BITS'($unsigned(sq_reg[3*i+2]));
        end

        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i] <= n_reg[i][CROSS_BITS-1] ? MAG_BITS'(-n_reg[i])
                                                 : MAG_BITS'(n_reg[i]);
        end
        l2_reg   <= l2_next;
        zero_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);

        for (int i = 0; i < 3; i++)
        begin
            msq_reg[i] <= C_BITS'(mag_reg[i]) * C_BITS'(mag_reg[i]);
        end
        l2sq_reg  <= L2SQ_BITS'(l2_reg) * L2SQ_BITS'(l2_reg);
        zero5_reg <= zero_reg;

        c_reg     <= msq_reg[0] + msq_reg[1] + msq_reg[2];
        l2sq6_reg <= l2sq_reg;
        zero6_reg <= zero5_reg;

        div_reg   <= c_reg;
        rem_reg   <= C_BITS'(r_hi);
        low_reg   <= r_ext[QUO_BITS-1:0];
        sat_reg   <= CMP_BITS'(r_hi) >= CMP_BITS'(c_reg);
        degen_reg <= zero6_reg;
    end

    assign ctl.valid = vld_reg[FRONT_STAGES-1];
    assign ctl.degen = degen_reg;
    assign ctl.sat   = sat_reg;
    assign divisor   = div_reg;
    assign rem       = rem_reg;
    assign low       = low_reg;

endmodule

/* rtl/core/trar_divider.sv */
`timescale 1ns / 1ps

module trar_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trar_pkg::trar_ctl_t             in_ctl,
    input  logic [trar_pkg::C_BITS-1:0]     in_divisor,
    input  logic [trar_pkg::C_BITS-1:0]     in_rem,
    input  logic [trar_pkg::QUO_BITS-1:0]   in_low,
    output trar_pkg::trar_ctl_t             out_ctl,
    output logic [trar_pkg::QUO_BITS-1:0]   quotient
);
    import trar_pkg::*;

    // one quotient bit per stage, restoring
    logic                vld_reg [QUO_BITS];
    trar_ctl_t           ctl_reg [QUO_BITS];
    logic [C_BITS-1:0]   div_reg [QUO_BITS];
    logic [C_BITS-1:0]   rem_reg [QUO_BITS];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        logic                s_vld;
        trar_ctl_t           s_ctl;
        logic [C_BITS-1:0]   s_div;
        logic [C_BITS-1:0]   s_rem;
        logic [QUO_BITS-1:0] s_low;
        logic [QUO_BITS-1:0] s_quo;
        logic [C_BITS:0]     shifted;
        logic                fits;

        if (k == 0)
        begin : g_first
            assign s_vld = in_ctl.valid;
            assign s_ctl = in_ctl;
            assign s_div = in_divisor;
            assign s_rem = in_rem;
            assign s_low = in_low;
            assign s_quo = '0;
        end
        else
        begin : g_next
            assign s_vld = vld_reg[k-1];
            assign s_ctl = ctl_reg[k-1];
            assign s_div = div_reg[k-1];
            assign s_rem = rem_reg[k-1];
            assign s_low = low_reg[k-1];
            assign s_quo = quo_reg[k-1];
        end

        assign shifted = {s_rem, s_low[QUO_BITS-1]};
        assign fits    = shifted >= {1'b0, s_div};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= s_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_reg[k] <= s_ctl;
            div_reg[k] <= s_div;
            rem_reg[k] <= fits ? C_BITS'(shifted - {1'b0, s_div}) : C_BITS'(shifted);
            low_reg[k] <= {s_low[QUO_BITS-2:0], 1'b0};
            quo_reg[k] <= {s_quo[QUO_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        out_ctl       = ctl_reg[QUO_BITS-1];
        out_ctl.valid = vld_reg[QUO_BITS-1];
    end
    assign quotient = quo_reg[QUO_BITS-1];

endmodule

/* rtl/core/trar_sqrt.sv */
`timescale 1ns / 1ps

module trar_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trar_pkg::trar_ctl_t             in_ctl,
    input  logic [trar_pkg::QUO_BITS-1:0]   radicand,
    output trar_pkg::trar_ctl_t             out_ctl,
    output logic [trar_pkg::ROOT_BITS-1:0]  root
);
    import trar_pkg::*;

    // one root bit per stage, two radicand bits consumed each
    logic                 vld_reg  [ROOT_BITS];
    trar_ctl_t            ctl_reg  [ROOT_BITS];
    logic [QUO_BITS-1:0]  x_reg    [ROOT_BITS];
    logic [ROOT_BITS:0]   rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        logic                 s_vld;
        trar_ctl_t            s_ctl;
        logic [QUO_BITS-1:0]  s_x;
        logic [ROOT_BITS:0]   s_rem;
        logic [ROOT_BITS-1:0] s_root;
        logic [ROOT_BITS+2:0] shifted;
        logic [ROOT_BITS+2:0] trial;
        logic                 fits;

        if (k == 0)
        begin : g_first
            assign s_vld  = in_ctl.valid;
            assign s_ctl  = in_ctl;
            assign s_x    = radicand;
            assign s_rem  = '0;
            assign s_root = '0;
        end
        else
        begin : g_next
            assign s_vld  = vld_reg[k-1];
            assign s_ctl  = ctl_reg[k-1];
            assign s_x    = x_reg[k-1];
            assign s_rem  = rem_reg[k-1];
            assign s_root = root_reg[k-1];
        end

        assign shifted = {s_rem, s_x[QUO_BITS-1:QUO_BITS-2]};
        assign trial   = {1'b0, s_root, 2'b01};
        assign fits    = shifted >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= s_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_reg[k]  <= s_ctl;
            x_reg[k]    <= {s_x[QUO_BITS-3:0], 2'b00};
            rem_reg[k]  <= fits ? (ROOT_BITS+1)'(shifted - trial) : (ROOT_BITS+1)'(shifted);
            root_reg[k] <= {s_root[ROOT_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        out_ctl       = ctl_reg[ROOT_BITS-1];
        out_ctl.valid = vld_reg[ROOT_BITS-1];
    end
    assign root = root_reg[ROOT_BITS-1];

endmodule

/* rtl/core/triangle_aspect_ratio_unit.sv */
`timescale 1ns / 1ps
// triangle aspect ratio unit: longest edge over the altitude onto that edge
//
// input channel: raise start for one cycle with the nine corner coordinates
// on corner*_x/y/z; the beat is taken at that edge whenever busy is low.
// busy never rises, so a new triangle may be sent in every cycle.
// output channel: done is high for exactly one cycle with aspect_ratio
// (unsigned q16.16, truncated, clamped to all ones) and degenerate (collinear
// or coincident corners, ratio then all ones). the receiver cannot stall;
// every result must be taken in the cycle it is shown.
// throughput: one triangle per clock.
// the depth is set by the 64 stage restoring divider (one quotient bit per
// stage) and the 32 stage square root (one root bit per stage) that follow
// a 7 stage geometry front end.
// reset clears all valid bits, so nothing in flight survives it; no result
// appears until a triangle is started after reset.

module triangle_aspect_ratio_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner0_x,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner0_y,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner0_z,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner1_x,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner1_y,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner1_z,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner2_x,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner2_y,
    input  logic [trar_pkg::COORD_BITS-1:0]     corner2_z,
    output logic                                done,
    output logic [trar_pkg::OUT_BITS-1:0]       aspect_ratio,
    output logic                                degenerate
);
    import trar_pkg::*;

    // front end to divider
    trar_ctl_t           f_ctl;
    logic [C_BITS-1:0]   f_div;
    logic [C_BITS-1:0]   f_rem;
    logic [QUO_BITS-1:0] f_low;

    // divider to square root
    trar_ctl_t           d_ctl;
    logic [QUO_BITS-1:0] d_quo;

    // square root to output
    trar_ctl_t            s_ctl;
    logic [ROOT_BITS-1:0] s_root;

    logic                done_reg;
    logic [OUT_BITS-1:0] ratio_reg;
    logic                degen_reg;

    // fully pipelined, always ready
    assign busy = 1'b0;

    trar_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .c0_x     (corner0_x),
        .c0_y     (corner0_y),
        .c0_z     (corner0_z),
        .c1_x     (corner1_x),
        .c1_y     (corner1_y),
        .c1_z     (corner1_z),
        .c2_x     (corner2_x),
        .c2_y     (corner2_y),
        .c2_z     (corner2_z),
        .ctl      (f_ctl),
        .divisor  (f_div),
        .rem      (f_rem),
        .low      (f_low)
    );

    // floor(L2^2 * 2^(2F) / C), only the low 64 bits; sat flags overflow
    trar_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (f_ctl),
        .in_divisor (f_div),
        .in_rem     (f_rem),
        .in_low     (f_low),
        .out_ctl    (d_ctl),
        .quotient   (d_quo)
    );

    // isqrt of the quotient gives the largest q with q^2 * C <= L2^2 * 2^(2F)
    trar_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (d_ctl),
        .radicand (d_quo),
        .out_ctl  (s_ctl),
        .root     (s_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s_ctl.valid;
        end
    end

    // a zero cross product always lands in the saturated case
    always_ff @(posedge clk)
    begin
        ratio_reg <= s_ctl.sat ? '1 : s_root;
        degen_reg <= s_ctl.degen;
    end

    assign done         = done_reg;
    assign aspect_ratio = ratio_reg;
    assign degenerate   = degen_reg;

    // every accepted beat produces a result
    a_start_done : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing after accepted beat");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result without accepted beat");

    a_degen_max : assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> aspect_ratio == '1)
        else $error("degenerate result not saturated");

endmodule
